// ===== src/strided_frame_history_blend_defines.svh =====
// assertion macros for the strided frame history blend
`ifndef STRIDED_FRAME_HISTORY_BLEND_DEFINES_SVH
`define STRIDED_FRAME_HISTORY_BLEND_DEFINES_SVH

// condition holds at every edge out of reset
`define SFHB_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SFHB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sfhb_pkg.sv =====
// shared types, constants and channel packing for the strided frame history blend
package sfhb_pkg;

    localparam int PIX_W  = 32;
    localparam int FP_W   = 13;
    localparam int Q_W    = 18;
    localparam int CH_W   = 6;
    localparam int SUM_W  = 8;
    localparam int LANES  = 4;

    localparam logic [FP_W-1:0] FP_RESET = 13'd4096;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [Q_W-1:0]   qpix_t;

    // quarter each colour channel and pack as r6 g6 b6
    function automatic qpix_t quarter_pack(input pixel_t px);
        quarter_pack = {px[23:18], px[15:10], px[7:2]};
    endfunction

endpackage

// ===== src/sfhb_ram.sv =====
// generic single write, single read ram with registered read data
module sfhb_ram
    import sfhb_pkg::*;
#(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/strided_frame_history_blend.sv =====
// top level of the strided frame history blend
//
// pixels arrive on the s_ stream, one 32-bit argb pixel per transfer; results
// leave on the m_ stream with the frame end flag on m_tlast.
// each output rgb channel is the sum of the quartered channel at the same
// position in four planes, current plane mod stride plus multiples of the stride.
// frame length is written through cfg_we / cfg_wdata by the user only while the
// block is idle; the block itself does not enforce it. the history sits in four
// copies of the plane store; each copy serves one of the four reads and all take
// the same write-back, so one pixel per clock is sustained. a write-back that
// meets a read of the next pixel is forwarded. a result is offered on m_tvalid
// once its pixel has passed stage 1 and been written into the output queue.
// throughput: one pixel per cycle while m_tready stays high. after reset a
// clearing pass zeroes all PLANE_COUNT * MAX_FRAME_PIXELS store entries (131072
// with the defaults); s_tready stays low until it ends, configuration writes are
// taken as ever. when the receiver stalls, a three-entry output queue absorbs
// the pixels in flight and s_tready drops once it cannot take another.
`include "strided_frame_history_blend_defines.svh"

module strided_frame_history_blend
    import sfhb_pkg::*;
#(
    parameter int PLANE_COUNT      = 32,
    parameter int PLANE_STRIDE     = 8,
    parameter int MAX_FRAME_PIXELS = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [31:0]     s_tdata,   // pixel_in
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,   // pixel_out
    output logic            m_tlast,
    input  logic            cfg_we,
    input  logic [FP_W-1:0] cfg_wdata
);

    localparam int DEPTH  = PLANE_COUNT * MAX_FRAME_PIXELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PL_W   = $clog2(PLANE_COUNT);
    localparam int SB_W   = (PLANE_STRIDE > 1) ? $clog2(PLANE_STRIDE) : 1;
    localparam int POS_W  = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
    localparam int CMP_W  = ((POS_W + 1 > FP_W) ? POS_W + 1 : FP_W) + 1;
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PW    = 2;
    localparam int FIFO_CW    = 3;

    typedef logic [ADDR_W-1:0] addr_t;

    // configuration and frame position
    logic [FP_W-1:0]  frame_pixels_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [PL_W-1:0]  cp_reg, cp_next;
    logic [SB_W-1:0]  base_reg, base_next;
    logic [PL_W-1:0]  lane_reg [LANES];

    // clearing pass
    logic             clr_active_reg;
    addr_t            clr_addr_reg;

    // stage 1
    logic             s1_valid_reg;
    pixel_t           s1_px_reg;
    logic             s1_last_reg;
    addr_t            s1_waddr_reg;
    logic [LANES-1:0] s1_cur_reg;
    logic [LANES-1:0] s1_fwd_reg;
    qpix_t            s1_fwd_data_reg;

    // output queue
    logic [PIX_W:0]     fifo_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0] head_reg, tail_reg;
    logic [FIFO_CW-1:0] fifo_cnt_reg;

    logic             accept;
    logic             frame_last;
    logic [CMP_W-1:0] fp_ext, len, pos_inc;
    addr_t            rd_addr [LANES];
    addr_t            wr_addr_cur;
    qpix_t            rdata [LANES];
    qpix_t            lane_q [LANES];
    logic [SUM_W-1:0] sum_r, sum_g, sum_b;
    pixel_t           result;
    qpix_t            wq;
    logic             ram_we;
    addr_t            ram_waddr;
    qpix_t            ram_wdata;
    logic             push, pop;

    assign s_tready = !clr_active_reg
                      && ((FIFO_CW'(fifo_cnt_reg) + FIFO_CW'(s1_valid_reg))
                          <= FIFO_CW'(FIFO_DEPTH - 1));
    assign accept   = s_tvalid && s_tready;

    // effective frame length and frame end
    always_comb
    begin
        fp_ext  = CMP_W'(frame_pixels_reg);
        pos_inc = CMP_W'(pos_reg) + CMP_W'(1);
        if (fp_ext == '0)
        begin
            len = CMP_W'(1);
        end
        else if (fp_ext > CMP_W'(MAX_FRAME_PIXELS))
        begin
            len = CMP_W'(MAX_FRAME_PIXELS);
        end
        else
        begin
            len = fp_ext;
        end
        frame_last = (pos_inc >= len);
    end

    always_comb
    begin
        pos_next  = pos_reg;
        cp_next   = cp_reg;
        base_next = base_reg;
        if (accept)
        begin
            if (frame_last)
            begin
                pos_next = '0;
                if (cp_reg == PL_W'(PLANE_COUNT - 1))
                begin
                    cp_next   = '0;
                    base_next = '0;
                end
                else
                begin
                    cp_next   = cp_reg + PL_W'(1);
                    base_next = (base_reg == SB_W'(PLANE_STRIDE - 1)) ? '0
                                                                     : base_reg + SB_W'(1);
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= FP_RESET;
            pos_reg          <= '0;
            cp_reg           <= '0;
            base_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_pixels_reg <= cfg_wdata;
            end
            pos_reg  <= pos_next;
            cp_reg   <= cp_next;
            base_reg <= base_next;
        end
    end

    // lane planes track (base + k * stride) mod plane count
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        localparam int LANE_INIT = (k * PLANE_STRIDE) % PLANE_COUNT;
        logic [PL_W-1:0] lane_next;

        always_comb
        begin
            lane_next = lane_reg[k];
            if (accept && frame_last)
            begin
                if (base_next == '0)
                begin
                    lane_next = PL_W'(LANE_INIT);
                end
                else
                begin
                    lane_next = (lane_reg[k] == PL_W'(PLANE_COUNT - 1)) ? '0
                                                                       : lane_reg[k] + PL_W'(1);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lane_reg[k] <= PL_W'(LANE_INIT);
            end
            else
            begin
                lane_reg[k] <= lane_next;
            end
        end

        assign rd_addr[k] = addr_t'(lane_reg[k]) * addr_t'(MAX_FRAME_PIXELS)
                            + addr_t'(pos_reg);

        // current plane takes the quartered input, a same-cycle write-back is forwarded
        assign lane_q[k] = s1_cur_reg[k] ? quarter_pack(s1_px_reg)
                         : s1_fwd_reg[k] ? s1_fwd_data_reg
                         : rdata[k];

        sfhb_ram #(
            .WIDTH (Q_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .raddr (rd_addr[k]),
            .rdata (rdata[k])
        );
    end

    assign wr_addr_cur = addr_t'(cp_reg) * addr_t'(MAX_FRAME_PIXELS) + addr_t'(pos_reg);

    // blend and write-back
    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < LANES; k++)
        begin
            sum_r = sum_r + SUM_W'(lane_q[k][17:12]);
            sum_g = sum_g + SUM_W'(lane_q[k][11:6]);
            sum_b = sum_b + SUM_W'(lane_q[k][5:0]);
        end
        result = {s1_px_reg[31:24], sum_r, sum_g, sum_b};
        wq     = quarter_pack(result);
    end

    assign ram_we    = clr_active_reg || s1_valid_reg;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_waddr_reg;
    assign ram_wdata = clr_active_reg ? '0 : wq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_addr_reg == addr_t'(DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + addr_t'(1);
                end
            end
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg       <= s_tdata;
            s1_last_reg     <= frame_last;
            s1_waddr_reg    <= wr_addr_cur;
            s1_fwd_data_reg <= wq;
            for (int k = 0; k < LANES; k++)
            begin
                s1_cur_reg[k] <= (lane_reg[k] == cp_reg);
                s1_fwd_reg[k] <= s1_valid_reg && (s1_waddr_reg == rd_addr[k]);
            end
        end
    end

    // output queue
    assign push     = s1_valid_reg;
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = fifo_mem[head_reg][PIX_W-1:0];
    assign m_tlast  = fifo_mem[head_reg][PIX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= (tail_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + FIFO_PW'(1);
            end
            if (pop)
            begin
                head_reg <= (head_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : head_reg + FIFO_PW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + FIFO_CW'(push) - FIFO_CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[tail_reg] <= {s1_last_reg, result};
        end
    end

    `SFHB_ASSERT(a_no_accept_while_clearing, !(clr_active_reg && s_tready), "transfer during clear")
    `SFHB_ASSERT(a_queue_bound,
        (FIFO_CW'(fifo_cnt_reg) + FIFO_CW'(s1_valid_reg)) <= FIFO_CW'(FIFO_DEPTH),
        "output queue overrun")
    `SFHB_ASSERT_NEXT(a_frame_end_wraps, accept && frame_last, pos_reg == '0,
        "position not wrapped at frame end")
    `SFHB_ASSERT_NEXT(a_stage_follows, accept, s1_valid_reg && !clr_active_reg,
        "accepted pixel missing from stage 1")

endmodule

// ===== tb/tb_strided_frame_history_blend.sv =====
// self-checking stream testbench for the strided frame history blend, with its own history predictor
module tb_strided_frame_history_blend;
    import sfhb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLANES     = 32;
    localparam int STRIDE     = 8;
    localparam int MAX_PIX    = 4096;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int SETTLE     = 8;
    localparam int PRINT_CAP  = 50;
    localparam int SAT_PIXELS = 300;
    localparam pixel_t ALPHA_MASK = 32'hFF00_0000;

    typedef struct packed {
        pixel_t pixel;
        logic   frame_end;
    } blend_result_t;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [31:0]     s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [31:0]     m_tdata;
    logic            m_tlast;
    logic            cfg_we;
    logic [FP_W-1:0] cfg_wdata;

    // predictor state
    qpix_t           history [PLANES*MAX_PIX];
    int              plane_idx;
    int              frame_pos;
    logic [FP_W-1:0] frame_len;

    blend_result_t   pending_results[$];
    int              error_count;
    int              cycle_count;
    int              pixels_sent;
    int              frames_seen;
    int              length_writes;
    bit              quiet;
    int              stall_left;

    strided_frame_history_blend #(
        .PLANE_COUNT      (PLANES),
        .PLANE_STRIDE     (STRIDE),
        .MAX_FRAME_PIXELS (MAX_PIX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("strided_frame_history_blend regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    function automatic blend_result_t blend_pixel(input pixel_t px);
        blend_result_t res;
        int            len;
        int            slot;
        int            base;
        int            plane;
        int            sum;
        qpix_t         entry;
        len = (frame_len == 0) ? 1 : ((frame_len > MAX_PIX) ? MAX_PIX : int'(frame_len));
        slot = plane_idx * MAX_PIX + frame_pos;
        for (int ch = 0; ch < 3; ch++)
            entry[CH_W*ch +: CH_W] = px[SUM_W*ch + 2 +: CH_W];
        history[slot] = entry;
        base = plane_idx % STRIDE;
        res.pixel = px & ALPHA_MASK;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = 0;
            for (int k = 0; k < LANES; k++)
            begin
                plane = (base + k * STRIDE) % PLANES;
                sum += history[plane * MAX_PIX + frame_pos][CH_W*ch +: CH_W];
            end
            res.pixel[SUM_W*ch +: SUM_W] = sum[SUM_W-1:0];
        end
        for (int ch = 0; ch < 3; ch++)
            entry[CH_W*ch +: CH_W] = res.pixel[SUM_W*ch + 2 +: CH_W];
        history[slot] = entry;
        res.frame_end = (frame_pos + 1 >= len);
        if (res.frame_end)
        begin
            frame_pos = 0;
            plane_idx = (plane_idx + 1) % PLANES;
        end
        else
            frame_pos++;
        return res;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        blend_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", m_tdata, '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.pixel)
                    report_mismatch("pixel", m_tdata, want.pixel);
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame end", {31'd0, m_tlast}, {31'd0, want.frame_end});
                if (m_tlast === 1'b1)
                    frames_seen++;
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        m_tready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            m_tready <= (stall_left == 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    task automatic send_pixel(input pixel_t px);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(blend_pixel(px));
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_frame_len(input logic [FP_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        frame_len = value;
        length_writes++;
        cfg_we <= 1'b0;
    endtask

    function automatic pixel_t random_pixel();
        case ($urandom_range(0, 7))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_0000;
            2: return 32'h00FC_FCFC;
            3: return {8'($urandom), 24'h030303};
            default: return $urandom;
        endcase
    endfunction

    // reset length of 4096, channel extremes, then a shrink past the current position
    task automatic test_reset_length_and_shrink();
        pixel_t corners [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000,
                                32'h00FF_FFFF, 32'h00FC_FCFC, 32'h0303_0303,
                                32'h8080_8080, 32'h7F7F_7F7F};
        foreach (corners[i])
            send_pixel(corners[i]);
        write_frame_len(13'd3);
        send_pixel(32'h1234_5678);
        send_pixel(32'hA5A5_A5A5);
    endtask

    // zero length acts as one: every pixel ends a frame and the plane steps each time
    task automatic test_zero_length();
        pixel_t seq [10] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'h0000_0000, 32'h8080_8080, 32'h7F7F_7F7F, 32'h0102_0304,
                             32'hFCFC_FCFC, 32'h0303_0303};
        write_frame_len('0);
        foreach (seq[i])
            send_pixel(seq[i]);
    endtask

    // an oversized length saturates to the longest frame, so no frame end for a long stretch
    task automatic test_saturated_length();
        write_frame_len({FP_W{1'b1}});
        repeat (SAT_PIXELS) send_pixel(random_pixel());
        write_frame_len(FP_RESET);
        repeat (3) send_pixel(random_pixel());
        write_frame_len(13'd2);
        repeat (4) send_pixel(random_pixel());
    endtask

    // short frames of random length, often left part-way before the next length change
    task automatic test_random_frames(input int target);
        int sent;
        int len;
        int eff;
        int frames;
        int count;
        sent = 0;
        while (sent < target)
        begin
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = 1;
                8: len = $urandom_range(9, 40);
                9: len = $urandom_range(41, 120);
                default: len = $urandom_range(2, 8);
            endcase
            write_frame_len(len[FP_W-1:0]);
            quiet = ($urandom_range(0, 3) == 0);
            eff = (len == 0) ? 1 : len;
            frames = $urandom_range(1, (160 / eff > 1) ? 160 / eff : 1);
            count = eff * frames + $urandom_range(0, eff - 1);
            repeat (count) send_pixel(random_pixel());
            sent += count;
            if ($urandom_range(0, 5) == 0)
                drain_results();
        end
        quiet = 1'b0;
    endtask

    // back-to-back transfers with no idling on either side
    task automatic test_steady_stream();
        quiet = 1'b1;
        write_frame_len(13'd5);
        repeat (200) send_pixel(random_pixel());
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        quiet         = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        pixels_sent   = 0;
        frames_seen   = 0;
        length_writes = 0;
        plane_idx     = 0;
        frame_pos     = 0;
        frame_len     = FP_RESET;
        foreach (history[i])
            history[i] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_length_and_shrink();
        test_zero_length();
        test_saturated_length();
        test_random_frames(1300);
        test_steady_stream();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("ran %0d pixels in %0d frames across %0d frame length writes", pixels_sent,
                 frames_seen, length_writes);
        $display("lengths covered: reset 4096, zero, one, saturating, shrink mid-frame, random");
        if (error_count == 0)
            $display("strided_frame_history_blend regression: pass");
        else
            $display("strided_frame_history_blend regression: fail");
        $finish;
    end

endmodule
